// ----- rtl/bcmc_pkg.sv -----
// Shared types and constants for the banked cartridge memory controller.
package bcmc_pkg;

	// Fixed geometry of the cartridge banks
	localparam int RAM_BANK_BYTES     = 8192;
	localparam int ROM_BANK_BYTES     = 16384;
	localparam int RAM_OFF_W          = $clog2(RAM_BANK_BYTES);
	localparam int ROM_OFF_W          = $clog2(ROM_BANK_BYTES);
	localparam int DEF_RAM_BANK_COUNT = 4;
	localparam int MAX_RAM_BANK_COUNT = 4;

	// Field widths
	localparam int BUS_ADDR_W  = 16;
	localparam int DATA_W      = 8;
	localparam int RAM_BANK_W  = 2;
	localparam int ROM_BANK_W  = 7;
	localparam int BACK_ADDR_W = 21;

	// Request codes
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Bus regions, decoded from the top three address bits (8 KiB each)
	localparam logic [2:0] RGN_RAM_ENABLE = 3'd0;
	localparam logic [2:0] RGN_ROM_BANK   = 3'd1;
	localparam logic [2:0] RGN_RAM_BANK   = 3'd2;
	localparam logic [2:0] RGN_LATCH      = 3'd3;
	localparam logic [2:0] RGN_VRAM       = 3'd4;
	localparam logic [2:0] RGN_EXT_RAM    = 3'd5;
	localparam logic [2:0] RGN_WRAM       = 3'd6;
	localparam logic [2:0] RGN_HIGH       = 3'd7;

	// Magic values
	localparam logic [3:0]        RAM_ENABLE_KEY    = 4'hA;
	localparam logic [DATA_W-1:0] RAM_DISABLED_BYTE = 8'hFF;
	localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;

	typedef struct packed {
		logic                  req_type;
		logic [BUS_ADDR_W-1:0] address;
		logic [DATA_W-1:0]     write_data;
	} bcmc_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]      read_data;
		logic                   use_backing;
		logic [BACK_ADDR_W-1:0] backing_address;
	} bcmc_rsp_t;

endpackage

// ----- rtl/banked_cartridge_memory_controller_unit.sv -----
// Top level of the banked cartridge memory controller: bank registers and cartridge RAM.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------------------------
//   req     | in  | req_valid/req_stall | req_type, address, write_data
//   rsp     | out | rsp_valid/rsp_stall | read_data, use_backing, backing_address
//
// One item per cycle while the result is not stalled; each item gives its result
// in the cycle after acceptance, set by the registered read of the cartridge RAM.
// Bank registers update at acceptance, so the next item sees them at once.
// Reset returns the bank registers to their defaults (ROM bank 1) and clears the
// output valid; RAM contents are undefined until written and need no clearing pass.
// A stalled result holds the output register and stalls req in the same cycle.
module banked_cartridge_memory_controller_unit
	import bcmc_pkg::*;
#(
	parameter int RAM_BANK_COUNT = DEF_RAM_BANK_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  bcmc_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output bcmc_rsp_t rsp
);

	localparam int MEM_DEPTH = RAM_BANK_COUNT * RAM_BANK_BYTES;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	typedef struct packed {
		logic                   is_write;
		logic                   sel_mem;
		logic [DATA_W-1:0]      rd_const;
		logic                   use_backing;
		logic [BACK_ADDR_W-1:0] backing_address;
	} bcmc_s1_t;

	logic [DATA_W-1:0] mem [MEM_DEPTH];
	logic [DATA_W-1:0] mem_rd_q;

	logic                  ram_enable_q;
	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [RAM_BANK_W-1:0] ram_bank_q;

	logic                  ram_enable_d;
	logic [ROM_BANK_W-1:0] rom_bank_d;
	logic [RAM_BANK_W-1:0] ram_bank_d;

	logic     valid_s1;
	bcmc_s1_t res_s1;
	bcmc_s1_t res_d;

	logic                          accept;
	logic [2:0]                    region;
	logic                          mem_we;
	logic                          mem_re;
	logic [RAM_BANK_W+RAM_OFF_W-1:0] ram_index;
	logic [MEM_AW-1:0]             mem_addr;

	// Advance whenever the output register is empty or being drained
	assign req_stall = valid_s1 && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign region    = req.address[BUS_ADDR_W-1 -: 3];

	// Bank is always below the bank count, so the truncation is exact
	assign ram_index = {ram_bank_q, req.address[RAM_OFF_W-1:0]};
	assign mem_addr  = ram_index[MEM_AW-1:0];

	// Decode the access: register updates, RAM strobes and the result
	always_comb begin
		ram_enable_d = ram_enable_q;
		rom_bank_d   = rom_bank_q;
		ram_bank_d   = ram_bank_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		res_d        = '0;
		res_d.is_write = req.req_type;
		if (req.req_type == REQ_WRITE) begin
			unique case (region)
				RGN_RAM_ENABLE: begin
					ram_enable_d = (req.write_data[3:0] == RAM_ENABLE_KEY);
				end
				RGN_ROM_BANK: begin
					rom_bank_d = (req.write_data[ROM_BANK_W-1:0] == '0) ?
						ROM_BANK_RESET : req.write_data[ROM_BANK_W-1:0];
				end
				RGN_RAM_BANK: begin
					if (int'(req.write_data) < RAM_BANK_COUNT) begin
						ram_bank_d = req.write_data[RAM_BANK_W-1:0];
					end
				end
				RGN_EXT_RAM: begin
					mem_we = ram_enable_q;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (region) inside
				RGN_RAM_BANK, RGN_LATCH: begin
					res_d.use_backing     = 1'b1;
					res_d.backing_address = {rom_bank_q, req.address[ROM_OFF_W-1:0]};
				end
				RGN_EXT_RAM: begin
					mem_re         = ram_enable_q;
					res_d.sel_mem  = ram_enable_q;
					res_d.rd_const = ram_enable_q ? '0 : RAM_DISABLED_BYTE;
				end
				default: begin
					res_d.use_backing     = 1'b1;
					res_d.backing_address = BACK_ADDR_W'(req.address);
				end
			endcase
		end
	end

	// Hold the bank registers until an item changes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q <= 1'b0;
			rom_bank_q   <= ROM_BANK_RESET;
			ram_bank_q   <= '0;
		end else if (accept) begin
			ram_enable_q <= ram_enable_d;
			rom_bank_q   <= rom_bank_d;
			ram_bank_q   <= ram_bank_d;
		end
	end

	// Cartridge RAM: at most one access per item, registered read data
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			mem[mem_addr] <= req.write_data;
		end
		if (accept && mem_re) begin
			mem_rd_q <= mem[mem_addr];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	// Drive the result, picking the RAM byte where the read used it
	assign rsp_valid           = valid_s1;
	assign rsp.read_data       = res_s1.sel_mem ? mem_rd_q : res_s1.rd_const;
	assign rsp.use_backing     = res_s1.use_backing;
	assign rsp.backing_address = res_s1.backing_address;

`ifndef SYNTHESIS
	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rom_bank_q != '0)
		else $error("ROM bank register holds zero");

	a_ram_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ram_bank_q) < RAM_BANK_COUNT)
		else $error("RAM bank register beyond bank count");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item gave no result");

	a_write_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && res_s1.is_write) |-> (rsp == '0))
		else $error("write item gave a nonzero result");
`endif

endmodule
